// File: rtl/sktm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sktm_pkg;
   localparam int TABLE_DEPTH = 4096;
   localparam int MAX_MOVES = 32;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = $clog2(MAX_MOVES);
   localparam int NW = $clog2(MAX_MOVES + 1);
   localparam int REC_W = 53;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [63:0] key;
      logic [5:0] from_square;
      logic [5:0] to_square;
      logic is_promotion;
      logic [7:0] promo_piece;
      logic [31:0] hit_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] match_total;
      logic [5:0] out_from;
      logic [5:0] out_to;
      logic out_promotion;
      logic [7:0] out_piece;
      logic [31:0] out_count;
      logic last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_W, S_SCAN, S_SCAN_W, S_SORT_RD, S_SORT_W,
      S_SORT_CMP, S_OUT_RD, S_OUT_W, S_OUT
   } state_type;
endpackage
`default_nettype wire

// File: rtl/sorted_key_table_match_lookup_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted key table lookup. Append and clear each return one response word. A query
// binary-searches the table memory (one read per probe), scans the matches
// into the match buffer, insertion-sorts them there (up to n*(n-1)/2 element
// moves), then emits one word per match, or a single no-match word if there
// are none. One item is worked at a time; each memory has a single read port.
module sorted_key_table_match_lookup_core import sktm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data
);
   state_type state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] first_ff, first_in, count_ff, count_in;
   logic [63:0] qkey_ff, qkey_in;
   logic [NW-1:0] n_ff, n_in;
   logic trunc_ff, trunc_in;
   logic [MW-1:0] i_ff, i_in, j_ff, j_in;
   logic [REC_W-1:0] cur_ff, cur_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   logic t_we;
   logic [AW-1:0] t_waddr, t_raddr;
   logic [63:0] t_rkey;
   logic [REC_W-1:0] t_rrec, wrec;
   logic b_we;
   logic [MW-1:0] b_waddr, b_raddr;
   logic [REC_W-1:0] b_wdata, b_rdata;
   logic accept, out_free;
   logic [CW-1:0] step;

   assign accept = req_valid && !req_stall;
   assign out_free = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign wrec = {req_data.from_square, req_data.to_square, req_data.is_promotion,
                  req_data.promo_piece, req_data.hit_count};
   assign step = count_ff >> 1;

   sktm_table u_table (.clock, .we(t_we), .waddr(t_waddr), .wkey(req_data.key),
      .wrec, .raddr(t_raddr), .rkey(t_rkey), .rrec(t_rrec));
   sktm_buffer u_buf (.clock, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .raddr(b_raddr), .rdata(b_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rv_ff <= rv_in;
      end
      first_ff <= first_in; count_ff <= count_in; qkey_ff <= qkey_in;
      n_ff <= n_in; trunc_ff <= trunc_in; i_ff <= i_in; j_ff <= j_in;
      cur_ff <= cur_in; rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff; total_in = total_ff; first_in = first_ff;
      count_in = count_ff; qkey_in = qkey_ff; n_in = n_ff; trunc_in = trunc_ff;
      i_in = i_ff; j_in = j_ff; cur_in = cur_ff; rsp_in = rsp_ff;
      rv_in = rv_ff && rsp_stall;
      t_we = 1'b0; t_waddr = total_ff[AW-1:0]; t_raddr = first_ff[AW-1:0];
      b_we = 1'b0; b_waddr = n_ff[MW-1:0]; b_wdata = t_rrec; b_raddr = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0; rsp_in.last = 1'b1;
               unique case (req_data.action)
                  ACT_APPEND: begin
                     rv_in = 1'b1;
                     if (total_ff >= CW'(TABLE_DEPTH)) rsp_in.status = ST_FULL;
                     else begin
                        t_we = 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     rv_in = 1'b1;
                     total_in = '0;
                  end
                  ACT_QUERY: begin
                     qkey_in = req_data.key; first_in = '0; count_in = total_ff;
                     n_in = '0; trunc_in = 1'b0;
                     state_in = S_SRCH;
                  end
                  default: ;
               endcase
            end
         end
         S_SRCH: begin
            t_raddr = AW'(first_ff + step);
            if (count_ff == '0) state_in = S_SCAN;
            else state_in = S_SRCH_W;
         end
         S_SRCH_W: begin
            if (t_rkey < qkey_ff) begin
               first_in = first_ff + step + 1'b1;
               count_in = count_ff - step - 1'b1;
            end else count_in = step;
            state_in = S_SRCH;
         end
         S_SCAN: begin
            if (first_ff >= total_ff) state_in = S_SORT_RD;
            else state_in = S_SCAN_W;
         end
         S_SCAN_W: begin
            if (t_rkey != qkey_ff) state_in = S_SORT_RD;
            else if (n_ff >= NW'(MAX_MOVES)) begin
               trunc_in = 1'b1; state_in = S_SORT_RD;
            end else begin
               b_we = 1'b1;
               n_in = n_ff + 1'b1; first_in = first_ff + 1'b1;
               state_in = S_SCAN;
            end
            i_in = MW'(1);
         end
         S_SORT_RD: begin
            if (n_ff == '0) begin
               if (out_free) begin
                  rsp_in = '0; rsp_in.status = ST_NONE; rsp_in.last = 1'b1;
                  rv_in = 1'b1; state_in = S_IDLE;
               end
            end else if (NW'(i_ff) >= n_ff || i_ff == '0) begin
               i_in = '0; state_in = S_OUT_RD;
            end else begin
               b_raddr = i_ff; j_in = i_ff; state_in = S_SORT_W;
            end
         end
         S_SORT_W: begin
            cur_in = b_rdata;
            b_raddr = j_ff - 1'b1;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            b_waddr = j_ff;
            b_we = 1'b1;
            if (b_rdata[31:0] < cur_ff[31:0]) begin
               b_wdata = b_rdata;
               j_in = j_ff - 1'b1;
               if (j_ff == MW'(1)) begin
                  state_in = S_SORT_CMP;
               end else begin
                  b_raddr = j_ff - MW'(2);
               end
               if (j_ff == MW'(1)) state_in = S_OUT_W;
            end else begin
               b_wdata = cur_ff;
               i_in = i_ff + 1'b1; state_in = S_SORT_RD;
            end
         end
         S_OUT_W: begin
            b_we = 1'b1; b_waddr = '0; b_wdata = cur_ff;
            i_in = i_ff + 1'b1; state_in = S_SORT_RD;
         end
         S_OUT_RD: begin
            b_raddr = i_ff; state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;
               rsp_in.status = trunc_ff ? ST_TRUNC : ST_OK;
               rsp_in.match_total = 6'(n_ff);
               rsp_in.out_from = b_rdata[52:47];
               rsp_in.out_to = b_rdata[46:41];
               rsp_in.out_promotion = b_rdata[40];
               rsp_in.out_piece = b_rdata[39:32];
               rsp_in.out_count = b_rdata[31:0];
               rsp_in.last = (NW'(i_ff) + 1'b1 == n_ff);
               if (rsp_in.last) state_in = S_IDLE;
               else begin
                  i_in = i_ff + 1'b1; state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(TABLE_DEPTH)) else $error("entry count over depth");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");
`endif
endmodule
`default_nettype wire

// File: rtl/sktm_table.sv
`timescale 1ns / 1ps
`default_nettype none
module sktm_table import sktm_pkg::*; (
   input wire logic clock,
   input wire logic we,
   input wire logic [AW-1:0] waddr,
   input wire logic [63:0] wkey,
   input wire logic [REC_W-1:0] wrec,
   input wire logic [AW-1:0] raddr,
   output logic [63:0] rkey,
   output logic [REC_W-1:0] rrec
);
   logic [63:0] key_mem [TABLE_DEPTH];
   logic [REC_W-1:0] rec_mem [TABLE_DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[waddr] <= wkey;
         rec_mem[waddr] <= wrec;
      end
      rkey <= key_mem[raddr];
      rrec <= rec_mem[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/sktm_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
module sktm_buffer import sktm_pkg::*; (
   input wire logic clock,
   input wire logic we,
   input wire logic [MW-1:0] waddr,
   input wire logic [REC_W-1:0] wdata,
   input wire logic [MW-1:0] raddr,
   output logic [REC_W-1:0] rdata
);
   logic [REC_W-1:0] mem [MAX_MOVES];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
